FILE: rtl/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants of the thick line rasterizer: register codes,
// item codes, the register set and the fixed limits of the pixel scan.
// ----------------------------------------------------------------------------
package tlr_pkg;

   localparam int unsigned LIMIT_BITS  = 12;
   localparam int unsigned RADIUS_BITS = 2;
   localparam int unsigned COLOR_BITS  = 32;
   localparam int unsigned PIX_BITS    = 11;
   localparam int unsigned CSR_IDX_BITS  = 2;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [LIMIT_BITS-1:0]  PIXEL_LIMIT = 12'd2048;
   localparam logic [RADIUS_BITS-1:0] MAX_RADIUS  = 2'd3;

   localparam logic [LIMIT_BITS-1:0]  WIDTH_RESET  = 12'd512;
   localparam logic [LIMIT_BITS-1:0]  HEIGHT_RESET = 12'd512;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 2'd1;
   localparam logic [COLOR_BITS-1:0]  COLOR_RESET  = 32'hFF0000FF;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BRUSH_RADIUS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DRAW_COLOR   = 2'd3;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   typedef struct packed {
      logic [LIMIT_BITS-1:0]  image_width;
      logic [LIMIT_BITS-1:0]  image_height;
      logic [RADIUS_BITS-1:0] brush_radius;
      logic [COLOR_BITS-1:0]  draw_color;
   } csr_regs_type;

   typedef enum logic [1:0] {
      BACK_IDLE = 2'b01,
      BACK_SCAN = 2'b10
   } back_state_type;

endpackage

FILE: rtl/tlr_front.sv
// ----------------------------------------------------------------------------
// tlr_front
// Takes start and step items, keeps the Bresenham line state and pushes one
// stamp position into the stamp queue for every item that draws.
// ----------------------------------------------------------------------------
module tlr_front import tlr_pkg::*; #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_func,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_finish_x,
   input  logic signed [COORD_BITS-1:0] req_finish_y,
   input  logic                         q_full,
   output logic                         q_push,
   output logic signed [COORD_BITS-1:0] q_x,
   output logic signed [COORD_BITS-1:0] q_y,
   output logic                         q_endp
);

   localparam int unsigned C = COORD_BITS;

   logic signed [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [C-1:0] end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic        [C-1:0] span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic                dir_x_neg_ff, dir_x_neg_in, dir_y_neg_ff, dir_y_neg_in;
   logic signed [C:0]   err_ff, err_in;
   logic                finished_ff, finished_in;

   logic                accept, is_start, emit, endp;
   logic signed [C:0]   dx, dy;
   logic        [C-1:0] ax, ay;
   logic signed [C:0]   err_init;
   logic signed [C+1:0] e2, sx_s, sy_s;
   logic signed [C+2:0] err_w, sx_w, sy_w, err_next;
   logic                cond_x, cond_y;
   logic signed [C-1:0] step_x, step_y;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign is_start = (req_func == FUNC_START);
   assign emit     = is_start || !finished_ff;

   // start: spans, directions and first error term
   assign dx = (C+1)'(req_finish_x) - (C+1)'(req_start_x);
   assign dy = (C+1)'(req_finish_y) - (C+1)'(req_start_y);
   assign ax = dx[C] ? C'(-dx) : dx[C-1:0];
   assign ay = dy[C] ? C'(-dy) : dy[C-1:0];
   assign err_init = (C+1)'(ax) - (C+1)'(ay);

   // step: one Bresenham move
   assign e2   = $signed({err_ff, 1'b0});
   assign sx_s = (C+2)'(span_x_ff);
   assign sy_s = (C+2)'(span_y_ff);
   assign cond_x = e2 > -sy_s;
   assign cond_y = e2 < sx_s;
   assign err_w = (C+3)'(err_ff);
   assign sx_w  = (C+3)'(span_x_ff);
   assign sy_w  = (C+3)'(span_y_ff);
   always_comb begin
      err_next = err_w;
      if (cond_x) begin
         err_next = err_next - sy_w;
      end
      if (cond_y) begin
         err_next = err_next + sx_w;
      end
   end
   assign step_x = !cond_x ? cur_x_ff :
                   dir_x_neg_ff ? cur_x_ff - C'(1) : cur_x_ff + C'(1);
   assign step_y = !cond_y ? cur_y_ff :
                   dir_y_neg_ff ? cur_y_ff - C'(1) : cur_y_ff + C'(1);

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      err_in       = err_ff;
      if (is_start) begin
         cur_x_in     = req_start_x;
         cur_y_in     = req_start_y;
         end_x_in     = req_finish_x;
         end_y_in     = req_finish_y;
         span_x_in    = ax;
         span_y_in    = ay;
         dir_x_neg_in = !(req_start_x < req_finish_x);
         dir_y_neg_in = !(req_start_y < req_finish_y);
         err_in       = err_init;
      end else begin
         cur_x_in = step_x;
         cur_y_in = step_y;
         err_in   = err_next[C:0];
      end
   end

   assign endp        = (cur_x_in == end_x_in) && (cur_y_in == end_y_in);
   assign finished_in = endp;

   assign q_push = accept && emit;
   assign q_x    = cur_x_in;
   assign q_y    = cur_y_in;
   assign q_endp = endp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         span_x_ff    <= '0;
         span_y_ff    <= '0;
         dir_x_neg_ff <= 1'b0;
         dir_y_neg_ff <= 1'b0;
         err_ff       <= '0;
         finished_ff  <= 1'b1;
      end else if (accept && emit) begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         span_x_ff    <= span_x_in;
         span_y_ff    <= span_y_in;
         dir_x_neg_ff <= dir_x_neg_in;
         dir_y_neg_ff <= dir_y_neg_in;
         err_ff       <= err_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

FILE: rtl/tlr_queue.sv
// ----------------------------------------------------------------------------
// tlr_queue
// Short first-in first-out queue of stamp positions between the line front
// and the pixel scan.
// ----------------------------------------------------------------------------
module tlr_queue import tlr_pkg::*; #(
   parameter int unsigned DATA_BITS = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] wdata,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] rdata,
   output logic                 empty
);

   localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0] mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   assign wr_ptr_in = !do_push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !do_pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/tlr_back.sv
// ----------------------------------------------------------------------------
// tlr_back
// Clips each queued stamp against the image and scans the remaining window
// row by row, one pixel write per cycle while the receiver pops.
// ----------------------------------------------------------------------------
module tlr_back import tlr_pkg::*; #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  csr_regs_type                 csr_regs,
   input  logic                         q_empty,
   input  logic signed [COORD_BITS-1:0] q_x,
   input  logic signed [COORD_BITS-1:0] q_y,
   input  logic                         q_endp,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [PIX_BITS-1:0]          rsp_pixel_x,
   output logic [PIX_BITS-1:0]          rsp_pixel_y,
   output logic [COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                         rsp_stamp_last,
   output logic                         rsp_at_endpoint
);

   localparam int unsigned SW = (COORD_BITS + 2 > LIMIT_BITS + 1) ?
                                COORD_BITS + 2 : LIMIT_BITS + 1;

   back_state_type state_ff, state_in;
   logic [PIX_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [PIX_BITS-1:0] xlo_ff, xlo_in, xhi_ff, xhi_in, yhi_ff, yhi_in;
   logic                endp_ff, endp_in;

   logic [RADIUS_BITS-1:0] r_eff;
   logic [LIMIT_BITS-1:0]  wlim, hlim;
   logic signed [SW-1:0]   r_s, wlim_s, hlim_s, cx, cy;
   logic signed [SW-1:0]   xlo_raw, xhi_raw, ylo_raw, yhi_raw;
   logic signed [SW-1:0]   xlo, xhi, ylo, yhi;
   logic                   stamp_ok, pop_ok, last, load;

   // clip window of the stamp at the queue head
   assign r_eff  = (csr_regs.brush_radius > MAX_RADIUS) ? MAX_RADIUS : csr_regs.brush_radius;
   assign wlim   = (csr_regs.image_width > PIXEL_LIMIT) ? PIXEL_LIMIT : csr_regs.image_width;
   assign hlim   = (csr_regs.image_height > PIXEL_LIMIT) ? PIXEL_LIMIT : csr_regs.image_height;
   assign r_s    = SW'(r_eff);
   assign wlim_s = SW'(wlim);
   assign hlim_s = SW'(hlim);
   assign cx     = SW'(q_x);
   assign cy     = SW'(q_y);

   assign xlo_raw = cx - r_s;
   assign xhi_raw = cx + r_s;
   assign ylo_raw = cy - r_s;
   assign yhi_raw = cy + r_s;
   assign xlo = (xlo_raw < 0) ? '0 : xlo_raw;
   assign ylo = (ylo_raw < 0) ? '0 : ylo_raw;
   assign xhi = (xhi_raw >= wlim_s) ? wlim_s - SW'(1) : xhi_raw;
   assign yhi = (yhi_raw >= hlim_s) ? hlim_s - SW'(1) : yhi_raw;
   assign stamp_ok = (xlo <= xhi) && (ylo <= yhi);

   assign pop_ok = (state_ff == BACK_SCAN) && rsp_pop;
   assign last   = (px_ff == xhi_ff) && (py_ff == yhi_ff);
   assign load   = !q_empty && ((state_ff == BACK_IDLE) || (pop_ok && last));
   assign q_pop  = load;

   always_comb begin
      state_in = state_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      xlo_in   = xlo_ff;
      xhi_in   = xhi_ff;
      yhi_in   = yhi_ff;
      endp_in  = endp_ff;
      if (load) begin
         state_in = stamp_ok ? BACK_SCAN : BACK_IDLE;
         px_in    = xlo[PIX_BITS-1:0];
         py_in    = ylo[PIX_BITS-1:0];
         xlo_in   = xlo[PIX_BITS-1:0];
         xhi_in   = xhi[PIX_BITS-1:0];
         yhi_in   = yhi[PIX_BITS-1:0];
         endp_in  = q_endp;
      end else begin
         unique case (state_ff)
            BACK_IDLE: begin
               state_in = BACK_IDLE;
            end
            BACK_SCAN: begin
               if (pop_ok) begin
                  if (last) begin
                     state_in = BACK_IDLE;
                  end else if (px_ff == xhi_ff) begin
                     px_in = xlo_ff;
                     py_in = py_ff + 1'b1;
                  end else begin
                     px_in = px_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_in = BACK_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      xlo_ff  <= xlo_in;
      xhi_ff  <= xhi_in;
      yhi_ff  <= yhi_in;
      endp_ff <= endp_in;
   end

   assign rsp_empty       = (state_ff != BACK_SCAN);
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_color = csr_regs.draw_color;
   assign rsp_stamp_last  = last;
   assign rsp_at_endpoint = endp_ff;

endmodule

FILE: rtl/thick_line_rasterizer.sv
// ----------------------------------------------------------------------------
// thick_line_rasterizer
// Bresenham line drawn with a square brush, emitted as clipped pixel writes.
// ----------------------------------------------------------------------------
// A start item loads both endpoints and stamps the brush at the first point;
// each step item moves one Bresenham step and stamps again, until the stamp
// at the endpoint has gone out. The front takes one item per cycle while the
// queue is not full and pushes each stamp into a two-entry queue; the back
// scans the clipped stamp row by row and sends one pixel write per cycle
// while the receiver pops, writing only the pixels of the stamp that lie
// inside the image, at most (2r+1)^2 (9 at radius 1). The back's one-pixel-
// per-cycle scan sets the sustained rate; up to two stamps wait in the queue
// while the current one drains.
// ----------------------------------------------------------------------------
module thick_line_rasterizer import tlr_pkg::*; #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_func,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_finish_x,
   input  logic signed [COORD_BITS-1:0] req_finish_y,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [PIX_BITS-1:0]          rsp_pixel_x,
   output logic [PIX_BITS-1:0]          rsp_pixel_y,
   output logic [COLOR_BITS-1:0]        rsp_pixel_color,
   output logic                         rsp_stamp_last,
   output logic                         rsp_at_endpoint
);

   localparam int unsigned QW = 2 * COORD_BITS + 1;

   csr_regs_type csr_ff, csr_in;

   logic                         q_push, q_full, q_pop, q_empty, f_endp;
   logic signed [COORD_BITS-1:0] f_x, f_y;
   logic [QW-1:0]                q_wdata, q_rdata;
   logic signed [COORD_BITS-1:0] b_x, b_y;
   logic                         b_endp;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  csr_in.image_width  = csr_wdata[LIMIT_BITS-1:0];
            CSR_IMAGE_HEIGHT: csr_in.image_height = csr_wdata[LIMIT_BITS-1:0];
            CSR_BRUSH_RADIUS: csr_in.brush_radius = csr_wdata[RADIUS_BITS-1:0];
            CSR_DRAW_COLOR:   csr_in.draw_color   = csr_wdata[COLOR_BITS-1:0];
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.image_width  <= WIDTH_RESET;
         csr_ff.image_height <= HEIGHT_RESET;
         csr_ff.brush_radius <= RADIUS_RESET;
         csr_ff.draw_color   <= COLOR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   tlr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_func     (req_func),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_finish_x (req_finish_x),
      .req_finish_y (req_finish_y),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_x          (f_x),
      .q_y          (f_y),
      .q_endp       (f_endp)
   );

   assign q_wdata = {f_x, f_y, f_endp};

   tlr_queue #(.DATA_BITS(QW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign b_x    = q_rdata[QW-1 -: COORD_BITS];
   assign b_y    = q_rdata[COORD_BITS:1];
   assign b_endp = q_rdata[0];

   tlr_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_regs        (csr_ff),
      .q_empty         (q_empty),
      .q_x             (b_x),
      .q_y             (b_y),
      .q_endp          (b_endp),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_stamp_last  (rsp_stamp_last),
      .rsp_at_endpoint (rsp_at_endpoint)
   );

endmodule

FILE: rtl/tlr_checker.sv
// ----------------------------------------------------------------------------
// tlr_checker
// Port-level checks of the pixel write stream of the thick line rasterizer.
// ----------------------------------------------------------------------------
module tlr_checker import tlr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [PIX_BITS-1:0]   rsp_pixel_x,
   input logic [PIX_BITS-1:0]   rsp_pixel_y,
   input logic [COLOR_BITS-1:0] rsp_pixel_color,
   input logic                  rsp_stamp_last,
   input logic                  rsp_at_endpoint
);

   // nothing to deliver right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   // a waiting item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
          && $stable(rsp_pixel_color) && $stable(rsp_stamp_last)
          && $stable(rsp_at_endpoint)))
      else $error("waiting item changed");

   // a stamp runs on without gaps and keeps its endpoint flag
   a_stamp_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_stamp_last) |=>
         (!rsp_empty && rsp_at_endpoint == $past(rsp_at_endpoint)))
      else $error("stamp broken before its last pixel");

   // within a stamp rows only move down by one
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_stamp_last) |=>
         (rsp_pixel_y == $past(rsp_pixel_y)
          || rsp_pixel_y == $past(rsp_pixel_y) + 11'd1))
      else $error("stamp rows out of order");

endmodule

bind thick_line_rasterizer tlr_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_stamp_last  (rsp_stamp_last),
   .rsp_at_endpoint (rsp_at_endpoint)
);
